### design/ael_pkg.sv
// Shared types, token kinds, scan modes and character codes for the expression lexer.
`default_nettype none
package ael_pkg;

    // Position counter saturation limit: the smaller of the source length bound and 65535
    localparam longint unsigned MAX_SOURCE_LEN = 64'd65535;
    localparam logic [15:0] POS_LIMIT =
        (MAX_SOURCE_LEN > 64'd65535) ? 16'hFFFF : MAX_SOURCE_LEN[15:0];

    localparam logic [3:0] K_END    = 4'd0;
    localparam logic [3:0] K_PLUS   = 4'd1;
    localparam logic [3:0] K_MINUS  = 4'd2;
    localparam logic [3:0] K_STAR   = 4'd3;
    localparam logic [3:0] K_POW    = 4'd4;
    localparam logic [3:0] K_SLASH  = 4'd5;
    localparam logic [3:0] K_MOD    = 4'd6;
    localparam logic [3:0] K_LPAREN = 4'd7;
    localparam logic [3:0] K_RPAREN = 4'd8;
    localparam logic [3:0] K_INT    = 4'd9;
    localparam logic [3:0] K_FLOAT  = 4'd10;
    localparam logic [3:0] K_UNREC  = 4'd11;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_STAR = 2'd1;
    localparam logic [1:0] MODE_INT  = 2'd2;
    localparam logic [1:0] MODE_FRAC = 2'd3;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
    } token_t;

    // Results caused by one source character, slot 0 first
    typedef struct packed {
        token_t [MAX_RESULTS-1:0] tok;
        logic [1:0]               cnt;
    } res_t;

endpackage
`default_nettype wire

### design/ael_scan.sv
// Scan state and token generation for one source character.
`default_nettype none
module ael_scan
    import ael_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] in_ch,
    input  wire logic       in_last,
    input  wire logic       adv,
    output res_t            res
);

    logic [1:0]  mode_reg, mode_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] tsp_reg, tsp_next;

    function automatic logic [15:0] span(input logic [15:0] upto, input logic [15:0] from);
        span = (upto >= from) ? (upto - from) : 16'd0;
    endfunction

    logic        is_digit, is_space, cons;
    logic [1:0]  m1;
    logic [15:0] t1, posn;
    logic [3:0]  cv;
    token_t      cand [4];
    logic [1:0]  n;

    always_comb begin
        is_digit = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
        is_space = (in_ch == CH_SPACE) || ((in_ch >= CH_TAB) && (in_ch <= CH_CR));
        cons = 1'b0;
        m1   = mode_reg;
        t1   = tsp_reg;
        cv   = 4'b0000;
        for (int i = 0; i < 4; i++) begin
            cand[i] = '{kind: K_END, start: 16'd0, length: 16'd0};
        end

        // extend or flush the pending token
        unique case (mode_reg)
            MODE_STAR: begin
                cv[0] = 1'b1;
                m1    = MODE_IDLE;
                if (in_ch == CH_STAR) begin
                    cand[0] = '{kind: K_POW, start: tsp_reg, length: 16'd2};
                    cons    = 1'b1;
                end else begin
                    cand[0] = '{kind: K_STAR, start: tsp_reg, length: 16'd1};
                end
            end
            MODE_INT: begin
                if (is_digit) begin
                    cons = 1'b1;
                end else if (in_ch == CH_DOT) begin
                    cons = 1'b1;
                    m1   = MODE_FRAC;
                end else begin
                    cv[0]   = 1'b1;
                    m1      = MODE_IDLE;
                    cand[0] = '{kind: K_INT, start: tsp_reg,
                                length: span(pos_reg, tsp_reg)};
                end
            end
            MODE_FRAC: begin
                if (is_digit) begin
                    cons = 1'b1;
                end else begin
                    cv[0]   = 1'b1;
                    m1      = MODE_IDLE;
                    cand[0] = '{kind: K_FLOAT, start: tsp_reg,
                                length: span(pos_reg, tsp_reg)};
                end
            end
            default: begin
            end
        endcase

        // scan the character afresh from idle
        if (!cons) begin
            cand[1] = '{kind: K_UNREC, start: pos_reg, length: 16'd1};
            priority if (in_ch == CH_PLUS) begin
                cv[1] = 1'b1; cand[1].kind = K_PLUS;
            end else if (in_ch == CH_MINUS) begin
                cv[1] = 1'b1; cand[1].kind = K_MINUS;
            end else if (in_ch == CH_SLASH) begin
                cv[1] = 1'b1; cand[1].kind = K_SLASH;
            end else if (in_ch == CH_PCT) begin
                cv[1] = 1'b1; cand[1].kind = K_MOD;
            end else if (in_ch == CH_LPAREN) begin
                cv[1] = 1'b1; cand[1].kind = K_LPAREN;
            end else if (in_ch == CH_RPAREN) begin
                cv[1] = 1'b1; cand[1].kind = K_RPAREN;
            end else if (in_ch == CH_STAR) begin
                m1 = MODE_STAR; t1 = pos_reg;
            end else if (is_digit) begin
                m1 = MODE_INT; t1 = pos_reg;
            end else if (!is_space) begin
                cv[1] = 1'b1;
            end else begin
            end
        end

        posn = (pos_reg < POS_LIMIT) ? (pos_reg + 16'd1) : POS_LIMIT;

        mode_next = m1;
        tsp_next  = t1;
        pos_next  = posn;

        // last character: flush, then end of input, then back to reset state
        if (in_last) begin
            cv[2] = (m1 != MODE_IDLE);
            unique case (m1)
                MODE_STAR: cand[2] = '{kind: K_STAR, start: t1, length: 16'd1};
                MODE_INT:  cand[2] = '{kind: K_INT, start: t1, length: span(posn, t1)};
                MODE_FRAC: cand[2] = '{kind: K_FLOAT, start: t1, length: span(posn, t1)};
                default:   cand[2] = '{kind: K_END, start: 16'd0, length: 16'd0};
            endcase
            cv[3]     = 1'b1;
            cand[3]   = '{kind: K_END, start: posn, length: 16'd0};
            mode_next = MODE_IDLE;
            tsp_next  = 16'd0;
            pos_next  = 16'd0;
        end

        // pack present tokens into the low slots
        n   = 2'd0;
        res = '0;
        for (int i = 0; i < 4; i++) begin
            if (cv[i] && (n != 2'd3)) begin
                res.tok[n] = cand[i];
                n          = n + 2'd1;
            end
        end
        res.cnt = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            pos_reg  <= 16'd0;
            tsp_reg  <= 16'd0;
        end else if (adv) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            tsp_reg  <= tsp_next;
        end
    end

endmodule
`default_nettype wire

### design/ael_obuf.sv
// Result buffer: holds up to three tokens of one character and hands them out a beat at a time.
`default_nettype none
module ael_obuf
    import ael_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic load,
    input  wire res_t res,
    output logic      free,
    output logic      out_valid,
    output token_t    out_tok,
    output logic      out_last,
    input  wire logic out_ready
);

    token_t [MAX_RESULTS-1:0] slot_reg;
    logic [1:0]               cnt_reg;
    logic                     pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_tok   = slot_reg[0];
    assign out_last  = (cnt_reg == 2'd1);
    assign free      = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= res.cnt;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // advance the queue on each beat taken
    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= res.tok;
        end else if (pop) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule
`default_nettype wire

### design/arithmetic_expression_lexer.sv
// Top level of the streaming arithmetic expression lexer.
// Path: a character's beat is held in the input register, then its tokens in the result
//   buffer; a character yields zero to three token beats.
// Throughput: one character per cycle while each gives at most one token and m_tready is high;
//   otherwise the result buffer drains one token per cycle and sets the rate.
// Reset: synchronous active-low aresetn empties both stages and returns the scanner to idle.
`default_nettype none
module arithmetic_expression_lexer
    import ael_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,   // end_of_source
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [3:0] token_kind, [19:4] token_start,
                                        // [35:20] token_length, [39:36] zero
    output logic             m_tlast    // last_of_run
);

    logic       in_vld_reg;
    logic [7:0] in_ch_reg;
    logic       in_last_reg;
    logic       adv, free;
    res_t       res;
    token_t     tok;

    assign adv      = in_vld_reg && free;
    assign s_tready = !in_vld_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ael_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_ch   (in_ch_reg),
        .in_last (in_last_reg),
        .adv     (adv),
        .res     (res)
    );

    ael_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (adv),
        .res       (res),
        .free      (free),
        .out_valid (m_tvalid),
        .out_tok   (tok),
        .out_last  (m_tlast),
        .out_ready (m_tready)
    );

    assign m_tdata = {4'b0000, tok.length, tok.start, tok.kind};

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (tok.kind == K_END)) |-> m_tlast)
        else $error("end token not last of run");
    a_end_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (tok.kind == K_END)) |-> (tok.length == 16'd0))
        else $error("end token with nonzero length");
    a_pow_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (tok.kind == K_POW)) |-> (tok.length == 16'd2))
        else $error("power token length not two");
`endif

endmodule
`default_nettype wire

### tb/ael_token_checker.sv
// Token checker for the expression lexer: predicts tokens from accepted characters and compares.
`timescale 1ns / 100ps
module ael_token_checker
    import ael_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] ch
    input  wire logic        s_tlast,    // end_of_source
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,    // [3:0] kind, [19:4] start, [35:20] length, [39:36] zero
    input  wire logic        m_tlast,    // last_of_run
    output int               mismatches,
    output int               tokens_owed
);

    typedef struct packed {
        token_t tok;
        logic   last;
    } due_tok_t;

    due_tok_t    tokens_due[$];
    due_tok_t    want;
    token_t      char_toks[MAX_RESULTS];
    int          char_tok_cnt;
    logic [1:0]  mode;
    logic [15:0] pos;
    logic [15:0] tok_start;

    initial begin
        mismatches  = 0;
        tokens_owed = 0;
    end

    task automatic add_tok(input logic [3:0] kind, input logic [15:0] start,
                           input logic [15:0] len);
        char_toks[char_tok_cnt].kind   = kind;
        char_toks[char_tok_cnt].start  = start;
        char_toks[char_tok_cnt].length = len;
        char_tok_cnt++;
    endtask

    // Emit whatever token is pending, ending just before offset upto
    task automatic flush_pending(input logic [15:0] upto);
        logic [15:0] span;
        span = (upto >= tok_start) ? upto - tok_start : 16'd0;
        case (mode)
            MODE_STAR: add_tok(K_STAR, tok_start, 16'd1);
            MODE_INT:  add_tok(K_INT, tok_start, span);
            MODE_FRAC: add_tok(K_FLOAT, tok_start, span);
            default: ;
        endcase
        mode = MODE_IDLE;
    endtask

    task automatic scan_char(input logic [7:0] c, input logic eos);
        logic [15:0] p;
        logic        digit;
        logic        taken;
        int          i;
        p            = pos;
        digit        = (c >= CH_ZERO) && (c <= CH_NINE);
        taken        = 1'b0;
        char_tok_cnt = 0;
        case (mode)
            MODE_STAR: begin
                if (c == CH_STAR) begin
                    add_tok(K_POW, tok_start, 16'd2);
                    mode  = MODE_IDLE;
                    taken = 1'b1;
                end else begin
                    flush_pending(p);
                end
            end
            MODE_INT: begin
                if (digit) begin
                    taken = 1'b1;
                end else if (c == CH_DOT) begin
                    mode  = MODE_FRAC;
                    taken = 1'b1;
                end else begin
                    flush_pending(p);
                end
            end
            MODE_FRAC: begin
                if (digit) begin
                    taken = 1'b1;
                end else begin
                    flush_pending(p);
                end
            end
            default: ;
        endcase
        // a character that ended the pending token is scanned afresh
        if (!taken) begin
            case (c)
                CH_PLUS:   add_tok(K_PLUS, p, 16'd1);
                CH_MINUS:  add_tok(K_MINUS, p, 16'd1);
                CH_SLASH:  add_tok(K_SLASH, p, 16'd1);
                CH_PCT:    add_tok(K_MOD, p, 16'd1);
                CH_LPAREN: add_tok(K_LPAREN, p, 16'd1);
                CH_RPAREN: add_tok(K_RPAREN, p, 16'd1);
                CH_STAR: begin
                    mode      = MODE_STAR;
                    tok_start = p;
                end
                default: begin
                    if (digit) begin
                        mode      = MODE_INT;
                        tok_start = p;
                    end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                        add_tok(K_UNREC, p, 16'd1);
                    end
                end
            endcase
        end
        pos = (p < POS_LIMIT) ? p + 16'd1 : POS_LIMIT;
        if (eos) begin
            flush_pending(pos);
            add_tok(K_END, pos, 16'd0);
            pos       = '0;
            tok_start = '0;
        end
        for (i = 0; i < char_tok_cnt; i++) begin
            tokens_due.push_back('{tok: char_toks[i], last: (i == char_tok_cnt - 1)});
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            tokens_due.delete();
            mode      = MODE_IDLE;
            pos       = '0;
            tok_start = '0;
        end else begin
            // compare the output beat first, so a same-edge result cannot match its own cause
            if (m_tvalid && m_tready) begin
                if (tokens_due.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected token beat kind %0d start %0d length %0d last %0b",
                                 $time, m_tdata[3:0], m_tdata[19:4], m_tdata[35:20], m_tlast);
                    end
                    mismatches++;
                end else begin
                    want = tokens_due.pop_front();
                    if (m_tdata[3:0] !== want.tok.kind || m_tdata[19:4] !== want.tok.start ||
                        m_tdata[35:20] !== want.tok.length || m_tdata[39:36] !== 4'd0 ||
                        m_tlast !== want.last) begin
                        if (mismatches < 10) begin
                            $display("%0t: token mismatch, expected kind %0d start %0d length %0d last %0b",
                                     $time, want.tok.kind, want.tok.start, want.tok.length,
                                     want.last);
                            $display("%0t:                 got kind %0d start %0d length %0d last %0b pad %0h",
                                     $time, m_tdata[3:0], m_tdata[19:4], m_tdata[35:20], m_tlast,
                                     m_tdata[39:36]);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                scan_char(s_tdata, s_tlast);
            end
        end
        tokens_owed = tokens_due.size();
    end

endmodule

### tb/arithmetic_expression_lexer_tb.sv
// Stimulus, clocking and verdict for the arithmetic expression lexer testbench.
`timescale 1ns / 100ps
module arithmetic_expression_lexer_tb
    import ael_pkg::*;
();

    localparam int WATCHDOG_CYCLES = 1000;
    localparam int RANDOM_CHARS    = 370;
    localparam int CALM_TAIL       = 40;
    localparam int SETTLE_CYCLES   = 20;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    int          mismatches;
    int          tokens_owed;
    int          quiet_cycles = 0;
    int          stall_left   = 0;
    logic        src_idle;
    logic        snk_idle;
    logic [7:0]  src_buf[$];

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    arithmetic_expression_lexer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    ael_token_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .tokens_owed (tokens_owed)
    );

    // Receiver: stall in bursts of random length while idling is on
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (snk_idle && $urandom_range(0, 6) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 10);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called and returning at a falling edge
    task automatic send_char(input logic [7:0] c, input logic eos);
        if (src_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic ship_src();
        int i;
        for (i = 0; i < src_buf.size(); i++) begin
            send_char(src_buf[i], i == src_buf.size() - 1);
        end
        src_buf.delete();
    endtask

    // Hold the sender until every token owed has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (tokens_owed != 0);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            src_buf.push_back(s[i]);
        end
    endtask

    task automatic push_blank();
        if ($urandom_range(0, 5) == 0) begin
            src_buf.push_back(CH_SPACE);
        end else begin
            src_buf.push_back(CH_TAB + 8'($urandom_range(0, 4)));
        end
    endtask

    task automatic add_ws();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) push_blank();
        end
    endtask

    task automatic push_digits(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) src_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_expr();
        int terms;
        int depth;
        int j;
        terms = $urandom_range(1, 6);
        depth = 0;
        for (j = 0; j < terms; j++) begin
            add_ws();
            if ($urandom_range(0, 3) == 0) begin
                src_buf.push_back(CH_LPAREN);
                depth++;
                add_ws();
            end
            if ($urandom_range(0, 5) == 0) begin
                src_buf.push_back(CH_MINUS);
            end
            push_digits(1, 4);
            if ($urandom_range(0, 2) == 0) begin
                src_buf.push_back(CH_DOT);
                push_digits(0, 3);
            end
            // break the sequence now and then
            if ($urandom_range(0, 11) == 0) begin
                src_buf.push_back(8'($urandom_range(0, 255)));
            end
            add_ws();
            if (depth > 0 && $urandom_range(0, 2) == 0) begin
                src_buf.push_back(CH_RPAREN);
                depth--;
                add_ws();
            end
            if (j < terms - 1) begin
                case ($urandom_range(0, 5))
                    0: src_buf.push_back(CH_PLUS);
                    1: src_buf.push_back(CH_MINUS);
                    2: src_buf.push_back(CH_STAR);
                    3: begin
                        src_buf.push_back(CH_STAR);
                        src_buf.push_back(CH_STAR);
                    end
                    4: src_buf.push_back(CH_SLASH);
                    default: src_buf.push_back(CH_PCT);
                endcase
            end
        end
        while (depth > 0) begin
            src_buf.push_back(CH_RPAREN);
            depth--;
        end
        add_ws();
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 4))
                0, 1: src_buf.push_back(8'($urandom_range(0, 255)));
                2: src_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                3: src_buf.push_back(CH_STAR);
                default: src_buf.push_back(CH_DOT);
            endcase
        end
    endtask

    initial begin
        int chars_sent;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        src_idle = 1'b1;
        snk_idle = 1'b1;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // operators, power, lone stars, second dot, odd bytes, empty fraction at the end
        add_text("(0.9.)**7 /%-+* *");
        src_buf.push_back(8'h00);
        src_buf.push_back(8'hFF);
        src_buf.push_back(8'h80);
        add_text(".3.");
        ship_src();
        add_text("*");
        ship_src();
        add_text(" ");
        ship_src();
        wait_drained();

        chars_sent = 0;
        while (chars_sent < RANDOM_CHARS) begin
            if (RANDOM_CHARS - chars_sent <= CALM_TAIL) begin
                src_idle = 1'b0;
                snk_idle = 1'b0;
            end else begin
                src_idle = ($urandom_range(0, 3) != 0);
                snk_idle = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 6) == 0) begin
                add_noise();
            end else begin
                add_expr();
            end
            chars_sent += src_buf.size();
            ship_src();
            if ($urandom_range(0, 9) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && tokens_owed == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### arithmetic_expression_lexer.f
design/ael_pkg.sv
design/ael_scan.sv
design/ael_obuf.sv
design/arithmetic_expression_lexer.sv
tb/ael_token_checker.sv
tb/arithmetic_expression_lexer_tb.sv
